### rtl/rmst_pkg.sv
// Shared types, constants and encodings for the range minimum sparse table.
`default_nettype none

package rmst_pkg;

   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_VALUE_WIDTH  = 32;

   localparam int MODE_W   = 2;
   localparam int ELEM_W   = 32;
   localparam int START_W  = 10;
   localparam int END_W    = 11;
   localparam int RESULT_W = 32;
   localparam int REQ_DATA_W = ((ELEM_W + START_W + END_W + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_LEVEL0,
      DP_STEP,
      DP_CLEAR,
      DP_QRD1,
      DP_QRD2,
      DP_QOUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              has_next;
      logic              q_err;
      logic              out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/range_minimum_sparse_table.sv
// Top level of the range minimum engine built on a sparse table.
//
// Items arrive on the req_ stream. req_tuser selects append, range query or
// clear. An append stores one element and then fills one new entry in each
// level that fits; a query returns the minimum over [range_start, range_end)
// on the rsp_ stream, with range_error set and a zero value when the range is
// empty or reaches past the loaded elements. Appends, clears and unused
// modes produce no result transfer.
// The block works on one item at a time. An append writes one table entry
// per level, starting at level 0, through the single write port; a query
// makes two reads on the one table read port before its result is
// registered, and a failing query skips both reads. A clear, an append to
// a full table or an unused mode finishes without any table access.
// The result register lets the next item be taken while a result waits; a
// query that finishes while the receiver stalls holds until rsp_tready.
// Reset empties the table, drops any pending result and holds req_tready low;
// table contents are not cleared, since only entries written after the last
// clear are read.
`default_nettype none

module range_minimum_sparse_table #(
   parameter int MAX_ELEMENTS = rmst_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_WIDTH  = rmst_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // element_value, range_start, range_end, zero pad.
   input  wire logic [rmst_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode.
   input  wire logic [rmst_pkg::MODE_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // minimum_value.
   output logic [rmst_pkg::RESULT_W-1:0]        rsp_tdata,
   // range_error.
   output logic                                 rsp_tuser
);

   rmst_pkg::dp_cmd_type    cmd;
   rmst_pkg::dp_status_type status;

   rmst_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rmst_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/rmst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/rmst_datapath.sv
// Datapath: element count, level walk, table memory, query compare and result register.
`default_nettype none

module rmst_datapath #(
   parameter int MAX_ELEMENTS = rmst_pkg::DEF_MAX_ELEMENTS,
   parameter int VALUE_WIDTH  = rmst_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [rmst_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [rmst_pkg::MODE_W-1:0]     req_tuser,
   input  wire rmst_pkg::dp_cmd_type            cmd,
   output rmst_pkg::dp_status_type              status,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [rmst_pkg::RESULT_W-1:0]        rsp_tdata,
   output logic                                 rsp_tuser
);

   localparam int IDX_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int LEVELS    = $clog2(MAX_ELEMENTS + 1);
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LC_W      = $clog2(LEVELS + 1);
   localparam int CMP_W     = (CNT_W > rmst_pkg::END_W) ? CNT_W : rmst_pkg::END_W;
   localparam int MEM_DEPTH = LEVELS * (2 ** IDX_W);
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   logic [rmst_pkg::ELEM_W-1:0]  value_ff;
   logic [rmst_pkg::START_W-1:0] lo_ff;
   logic [rmst_pkg::END_W-1:0]   hi_ff;
   logic [rmst_pkg::MODE_W-1:0]  mode_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [LC_W-1:0]              lvl_ff;
   logic [VALUE_WIDTH-1:0]       carry_ff;
   logic                         rsp_valid_ff;
   logic [rmst_pkg::RESULT_W-1:0] rsp_min_ff;
   logic                         rsp_err_ff;

   logic [VALUE_WIDTH-1:0] elem_w;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic [VALUE_WIDTH-1:0] min_val;
   logic [rmst_pkg::RESULT_W-1:0] min_out;
   logic [LC_W-1:0]        lvl_nxt;
   logic [CNT_W:0]         pos1;
   logic [CNT_W:0]         pw_cur;
   logic [CNT_W:0]         pw_nxt;
   logic [CNT_W:0]         start_cur;
   logic [CNT_W:0]         start_nxt;
   logic                   has_next;
   logic [CMP_W-1:0]       lo_ext;
   logic [CMP_W-1:0]       hi_ext;
   logic [CMP_W-1:0]       cnt_ext;
   logic [rmst_pkg::END_W-1:0] len;
   logic [LVL_W-1:0]       k;
   logic [CMP_W-1:0]       q_idx2;
   logic                   q_err;

   logic                   wr_en;
   logic [MEM_AW-1:0]      wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [MEM_AW-1:0]      rd_addr;

   generate
      if (VALUE_WIDTH <= rmst_pkg::ELEM_W) begin : g_in_narrow
         assign elem_w = value_ff[VALUE_WIDTH-1:0];
      end else begin : g_in_wide
         assign elem_w = {{(VALUE_WIDTH - rmst_pkg::ELEM_W){1'b0}}, value_ff};
      end
      if (VALUE_WIDTH < rmst_pkg::RESULT_W) begin : g_out_narrow
         assign min_out = {{(rmst_pkg::RESULT_W - VALUE_WIDTH){min_val[VALUE_WIDTH-1]}}, min_val};
      end else if (VALUE_WIDTH == rmst_pkg::RESULT_W) begin : g_out_equal
         assign min_out = min_val;
      end else begin : g_out_wide
         assign min_out = min_val[rmst_pkg::RESULT_W-1:0];
      end
   endgenerate

   always_comb begin
      min_val = ($signed(rd_data) <= $signed(carry_ff)) ? rd_data : carry_ff;
   end

   // Append walk: level lvl_ff is written at start_cur and read at start_nxt for the next step.
   always_comb begin
      lvl_nxt   = lvl_ff + LC_W'(1);
      pos1      = {1'b0, count_ff} + (CNT_W + 1)'(1);
      pw_cur    = (CNT_W + 1)'(1) << lvl_ff;
      pw_nxt    = (CNT_W + 1)'(1) << lvl_nxt;
      start_cur = pos1 - pw_cur;
      start_nxt = pos1 - pw_nxt;
      has_next  = (lvl_nxt < LC_W'(LEVELS)) && (pw_nxt <= pos1);
   end

   always_comb begin
      lo_ext  = CMP_W'(lo_ff);
      hi_ext  = CMP_W'(hi_ff);
      cnt_ext = CMP_W'(count_ff);
      q_err   = (hi_ext <= lo_ext) || (hi_ext > cnt_ext);
      len     = hi_ff - rmst_pkg::END_W'(lo_ff);
      k       = '0;
      for (int i = 0; i < rmst_pkg::END_W; i++) begin
         if (len[i]) begin
            k = LVL_W'(i);
         end
      end
      q_idx2  = hi_ext - (CMP_W'(1) << k);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = elem_w;
      rd_en   = 1'b0;
      rd_addr = MEM_AW'({lvl_ff[LVL_W-1:0], start_nxt[IDX_W-1:0]});
      case (cmd.op)
         rmst_pkg::DP_LEVEL0: begin
            wr_en   = 1'b1;
            wr_addr = MEM_AW'({{LVL_W{1'b0}}, count_ff[IDX_W-1:0]});
            wr_data = elem_w;
            rd_en   = has_next;
         end
         rmst_pkg::DP_STEP: begin
            wr_en   = 1'b1;
            wr_addr = MEM_AW'({lvl_ff[LVL_W-1:0], start_cur[IDX_W-1:0]});
            wr_data = min_val;
            rd_en   = has_next;
         end
         rmst_pkg::DP_QRD1: begin
            rd_en   = 1'b1;
            rd_addr = MEM_AW'({k, lo_ext[IDX_W-1:0]});
         end
         rmst_pkg::DP_QRD2: begin
            rd_en   = 1'b1;
            rd_addr = MEM_AW'({k, q_idx2[IDX_W-1:0]});
         end
         default: begin
         end
      endcase
   end

   rmst_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         rmst_pkg::DP_LOAD: begin
            value_ff <= req_tdata[rmst_pkg::ELEM_W-1:0];
            lo_ff    <= req_tdata[rmst_pkg::ELEM_W +: rmst_pkg::START_W];
            hi_ff    <= req_tdata[rmst_pkg::ELEM_W + rmst_pkg::START_W +: rmst_pkg::END_W];
            mode_ff  <= req_tuser;
            lvl_ff   <= '0;
         end
         rmst_pkg::DP_LEVEL0: begin
            carry_ff <= elem_w;
            lvl_ff   <= lvl_nxt;
         end
         rmst_pkg::DP_STEP: begin
            carry_ff <= min_val;
            lvl_ff   <= lvl_nxt;
         end
         rmst_pkg::DP_QRD2: begin
            carry_ff <= rd_data;
         end
         default: begin
         end
      endcase
      if (cmd.op == rmst_pkg::DP_QOUT) begin
         rsp_err_ff <= q_err;
         rsp_min_ff <= q_err ? '0 : min_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == rmst_pkg::DP_CLEAR) begin
            count_ff <= '0;
         end else if ((cmd.op == rmst_pkg::DP_LEVEL0 || cmd.op == rmst_pkg::DP_STEP)
                      && !has_next) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.op == rmst_pkg::DP_QOUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.mode     = mode_ff;
      status.full     = (count_ff == CNT_W'(MAX_ELEMENTS));
      status.has_next = has_next;
      status.q_err    = q_err;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_min_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

### rtl/rmst_controller.sv
// Controller state machine that sequences append, query and clear items.
`default_nettype none

module rmst_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output rmst_pkg::dp_cmd_type         cmd,
   input  wire rmst_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_STEP,
      ST_QRD2,
      ST_QOUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = rmst_pkg::DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.op   = rmst_pkg::DP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.mode)
               rmst_pkg::MODE_APPEND: begin
                  if (status.full) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.op   = rmst_pkg::DP_LEVEL0;
                     state_in = status.has_next ? ST_STEP : ST_IDLE;
                  end
               end
               rmst_pkg::MODE_QUERY: begin
                  if (status.q_err) begin
                     state_in = ST_QOUT;
                  end else begin
                     cmd.op   = rmst_pkg::DP_QRD1;
                     state_in = ST_QRD2;
                  end
               end
               rmst_pkg::MODE_CLEAR: begin
                  cmd.op   = rmst_pkg::DP_CLEAR;
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_STEP: begin
            cmd.op = rmst_pkg::DP_STEP;
            if (!status.has_next) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRD2: begin
            cmd.op   = rmst_pkg::DP_QRD2;
            state_in = ST_QOUT;
         end
         ST_QOUT: begin
            if (status.out_free) begin
               cmd.op   = rmst_pkg::DP_QOUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

`default_nettype wire
